[hw/rtl/slle_pkg.sv]
// ----------------------------------------------------------------------------
// slle_pkg
// Shared types and constants for the sorted linked list engine: command and
// status codes, controller states, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package slle_pkg;

  localparam int CMD_BITS   = 2;
  localparam int ID_BITS    = 5;
  localparam int KEY_W      = 32;
  localparam int COUNT_BITS = 6;
  localparam int STAT_BITS  = 2;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 48;
  localparam int M_PAD_W    = M_TDATA_W - (COUNT_BITS + STAT_BITS + 1 + ID_BITS + KEY_W);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CLEAR      = 2'd0,
    CMD_INS_CURSOR = 2'd1,
    CMD_INS_SORTED = 2'd2,
    CMD_REMOVE     = 2'd3
  } cmd_t;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_OK     = 2'd0,
    STAT_LISTED = 2'd1,
    STAT_ABSENT = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_WALK0,
    ST_WALK,
    ST_AT_RD,
    ST_NX_RD,
    ST_LINK1,
    ST_LINK2,
    ST_REM,
    ST_HEAD,
    ST_HEAD_K,
    ST_RESP
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_CLEAR,
    OP_FLAG,
    OP_KEY_PREV_CUR,
    OP_KEY_PREV_SENT,
    OP_KEY_NEXT_SENT,
    OP_READ_ID,
    OP_WALK_START,
    OP_WALK_STEP,
    OP_AT_LATCH,
    OP_NX_LATCH,
    OP_LINK1,
    OP_LINK2,
    OP_REM,
    OP_HEAD_RD,
    OP_HEADK_RD,
    OP_HOLD
  } op_t;

  typedef struct packed {
    op_t   op;
    stat_t stat;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic id_ok;
    logic listed;
    logic key_max;
    logic walk_go;
  } dp_stat_t;

endpackage

[hw/rtl/slle_ctrl.sv]
// ----------------------------------------------------------------------------
// slle_ctrl
// Controller state machine: sequences the datapath through decode, list walk,
// link update and head lookup for one request at a time.
// ----------------------------------------------------------------------------
module slle_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_free,
  output logic               out_load,
  output slle_pkg::dp_cmd_t  dp_cmd,
  input  slle_pkg::dp_stat_t dp_stat
);

  slle_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slle_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_load    = 1'b0;
    dp_cmd.op   = slle_pkg::OP_NONE;
    dp_cmd.stat = slle_pkg::STAT_OK;
    unique case (state)
      slle_pkg::ST_INIT: begin
        dp_cmd.op  = slle_pkg::OP_INIT;
        state_next = slle_pkg::ST_IDLE;
      end
      slle_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.op  = slle_pkg::OP_LOAD;
          state_next = slle_pkg::ST_DECODE;
        end
      end
      slle_pkg::ST_DECODE: begin
        priority if (dp_stat.cmd == slle_pkg::CMD_CLEAR) begin
          dp_cmd.op  = slle_pkg::OP_CLEAR;
          state_next = slle_pkg::ST_HEAD;
        end else if (!dp_stat.id_ok) begin
          dp_cmd.op   = slle_pkg::OP_FLAG;
          dp_cmd.stat = slle_pkg::STAT_ABSENT;
          state_next  = slle_pkg::ST_HEAD;
        end else if (dp_stat.cmd == slle_pkg::CMD_REMOVE) begin
          if (!dp_stat.listed) begin
            dp_cmd.op   = slle_pkg::OP_FLAG;
            dp_cmd.stat = slle_pkg::STAT_ABSENT;
            state_next  = slle_pkg::ST_HEAD;
          end else begin
            dp_cmd.op  = slle_pkg::OP_READ_ID;
            state_next = slle_pkg::ST_REM;
          end
        end else if (dp_stat.listed) begin
          dp_cmd.op   = slle_pkg::OP_FLAG;
          dp_cmd.stat = slle_pkg::STAT_LISTED;
          state_next  = slle_pkg::ST_HEAD;
        end else if (dp_stat.cmd == slle_pkg::CMD_INS_CURSOR) begin
          dp_cmd.op  = slle_pkg::OP_KEY_PREV_CUR;
          state_next = slle_pkg::ST_AT_RD;
        end else if (dp_stat.key_max) begin
          // A maximum key always lands at the tail.
          dp_cmd.op  = slle_pkg::OP_KEY_PREV_SENT;
          state_next = slle_pkg::ST_AT_RD;
        end else begin
          dp_cmd.op  = slle_pkg::OP_KEY_NEXT_SENT;
          state_next = slle_pkg::ST_WALK0;
        end
      end
      slle_pkg::ST_WALK0: begin
        dp_cmd.op  = slle_pkg::OP_WALK_START;
        state_next = slle_pkg::ST_WALK;
      end
      slle_pkg::ST_WALK: begin
        if (dp_stat.walk_go) begin
          dp_cmd.op = slle_pkg::OP_WALK_STEP;
        end else begin
          state_next = slle_pkg::ST_LINK1;
        end
      end
      slle_pkg::ST_AT_RD: begin
        dp_cmd.op  = slle_pkg::OP_AT_LATCH;
        state_next = slle_pkg::ST_NX_RD;
      end
      slle_pkg::ST_NX_RD: begin
        dp_cmd.op  = slle_pkg::OP_NX_LATCH;
        state_next = slle_pkg::ST_LINK1;
      end
      slle_pkg::ST_LINK1: begin
        dp_cmd.op  = slle_pkg::OP_LINK1;
        state_next = slle_pkg::ST_LINK2;
      end
      slle_pkg::ST_LINK2: begin
        dp_cmd.op  = slle_pkg::OP_LINK2;
        state_next = slle_pkg::ST_HEAD;
      end
      slle_pkg::ST_REM: begin
        dp_cmd.op  = slle_pkg::OP_REM;
        state_next = slle_pkg::ST_HEAD;
      end
      slle_pkg::ST_HEAD: begin
        dp_cmd.op  = slle_pkg::OP_HEAD_RD;
        state_next = slle_pkg::ST_HEAD_K;
      end
      slle_pkg::ST_HEAD_K: begin
        dp_cmd.op  = slle_pkg::OP_HEADK_RD;
        state_next = slle_pkg::ST_RESP;
      end
      slle_pkg::ST_RESP: begin
        dp_cmd.op = slle_pkg::OP_HOLD;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = slle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = slle_pkg::ST_INIT;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Sentinel initialization happens only once after reset.
  a_init_once: assert property (@(posedge clk) disable iff (rst)
    (state != slle_pkg::ST_INIT) |=> (state != slle_pkg::ST_INIT))
    else $error("controller re-entered init");
`endif

endmodule

[hw/rtl/slle_dp.sv]
// ----------------------------------------------------------------------------
// slle_dp
// Datapath: key and link memories, membership bits, cursor, item count and
// the walk registers, driven one operation per cycle by the controller.
// ----------------------------------------------------------------------------
module slle_dp #(
  parameter int SLOTS    = 32,
  parameter int KEY_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  slle_pkg::dp_cmd_t                 dp_cmd,
  output slle_pkg::dp_stat_t                dp_stat,
  input  logic [slle_pkg::CMD_BITS-1:0]     in_cmd,
  input  logic [slle_pkg::ID_BITS-1:0]      in_id,
  input  logic [slle_pkg::KEY_W-1:0]        in_key,
  output logic [slle_pkg::COUNT_BITS-1:0]   res_count,
  output slle_pkg::stat_t                   res_status,
  output logic                              res_empty,
  output logic [slle_pkg::ID_BITS-1:0]      res_head_item,
  output logic [slle_pkg::KEY_W-1:0]        res_head_key
);

  localparam int LW = $clog2(SLOTS + 1);
  localparam int KW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0]       SENT    = LW'(SLOTS);
  localparam logic [KEY_BITS-1:0] KEY_MAX = '1;

  // Index SLOTS of the link memories is the sentinel.
  logic [LW-1:0]       next_mem [SLOTS+1];
  logic [LW-1:0]       prev_mem [SLOTS+1];
  logic [KEY_BITS-1:0] key_mem  [SLOTS];

  logic                next_we, prev_we, key_we;
  logic                next_re, prev_re, key_re;
  logic [LW-1:0]       next_wa, next_wd, prev_wa, prev_wd, next_ra, prev_ra;
  logic [KW-1:0]       key_wa, key_ra;
  logic [KEY_BITS-1:0] key_wd;
  logic [LW-1:0]       next_rd, prev_rd;
  logic [KEY_BITS-1:0] key_rd;

  slle_pkg::cmd_t      cmd_r;
  slle_pkg::stat_t     status_r;
  logic                id_ok_r;
  logic [LW-1:0]       id_r;
  logic [KEY_BITS-1:0] key_r;
  logic [LW-1:0]       at, nx, head, cursor;
  logic [CW-1:0]       count;
  logic [SLOTS-1:0]    in_list;

  logic [KW-1:0]       id_k, next_rd_k;

  assign id_k      = id_r[KW-1:0];
  assign next_rd_k = (next_rd == SENT) ? '0 : next_rd[KW-1:0];

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (next_re) begin
      next_rd <= next_mem[next_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (prev_re) begin
      prev_rd <= prev_mem[prev_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (key_re) begin
      key_rd <= key_mem[key_ra];
    end
  end

  always_comb begin
    next_we = 1'b0;
    prev_we = 1'b0;
    key_we  = 1'b0;
    next_re = 1'b0;
    prev_re = 1'b0;
    key_re  = 1'b0;
    next_wa = '0;
    next_wd = '0;
    prev_wa = '0;
    prev_wd = '0;
    next_ra = '0;
    prev_ra = '0;
    key_wa  = id_k;
    key_wd  = key_r;
    key_ra  = '0;
    unique case (dp_cmd.op)
      slle_pkg::OP_INIT, slle_pkg::OP_CLEAR: begin
        next_we = 1'b1;
        next_wa = SENT;
        next_wd = SENT;
        prev_we = 1'b1;
        prev_wa = SENT;
        prev_wd = SENT;
      end
      slle_pkg::OP_KEY_PREV_CUR: begin
        key_we  = 1'b1;
        prev_re = 1'b1;
        prev_ra = cursor;
      end
      slle_pkg::OP_KEY_PREV_SENT: begin
        key_we  = 1'b1;
        prev_re = 1'b1;
        prev_ra = SENT;
      end
      slle_pkg::OP_KEY_NEXT_SENT: begin
        key_we  = 1'b1;
        next_re = 1'b1;
        next_ra = SENT;
      end
      slle_pkg::OP_READ_ID: begin
        next_re = 1'b1;
        next_ra = id_r;
        prev_re = 1'b1;
        prev_ra = id_r;
      end
      slle_pkg::OP_WALK_START, slle_pkg::OP_WALK_STEP: begin
        // Fetch the link and key of the node just reached in the same cycle.
        next_re = 1'b1;
        next_ra = next_rd;
        key_re  = 1'b1;
        key_ra  = next_rd_k;
      end
      slle_pkg::OP_AT_LATCH: begin
        next_re = 1'b1;
        next_ra = prev_rd;
      end
      slle_pkg::OP_LINK1: begin
        next_we = 1'b1;
        next_wa = id_r;
        next_wd = nx;
        prev_we = 1'b1;
        prev_wa = id_r;
        prev_wd = at;
      end
      slle_pkg::OP_LINK2: begin
        next_we = 1'b1;
        next_wa = at;
        next_wd = id_r;
        prev_we = 1'b1;
        prev_wa = nx;
        prev_wd = id_r;
      end
      slle_pkg::OP_REM: begin
        prev_we = 1'b1;
        prev_wa = next_rd;
        prev_wd = prev_rd;
        next_we = 1'b1;
        next_wa = prev_rd;
        next_wd = next_rd;
      end
      slle_pkg::OP_HEAD_RD: begin
        next_re = 1'b1;
        next_ra = SENT;
      end
      slle_pkg::OP_HEADK_RD: begin
        key_re = 1'b1;
        key_ra = next_rd_k;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_list  <= '0;
      count    <= '0;
      cursor   <= SENT;
      status_r <= slle_pkg::STAT_OK;
    end else begin
      unique case (dp_cmd.op)
        slle_pkg::OP_LOAD: begin
          status_r <= slle_pkg::STAT_OK;
        end
        slle_pkg::OP_CLEAR: begin
          in_list <= '0;
          count   <= '0;
          cursor  <= SENT;
        end
        slle_pkg::OP_FLAG: begin
          status_r <= dp_cmd.stat;
        end
        slle_pkg::OP_LINK2: begin
          in_list[id_k] <= 1'b1;
          count         <= count + CW'(1);
        end
        slle_pkg::OP_REM: begin
          in_list[id_k] <= 1'b0;
          count         <= count - CW'(1);
          if (cursor == id_r) begin
            cursor <= prev_rd;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (dp_cmd.op)
      slle_pkg::OP_LOAD: begin
        cmd_r   <= slle_pkg::cmd_t'(in_cmd);
        id_r    <= LW'(in_id);
        id_ok_r <= ({{(32 - slle_pkg::ID_BITS){1'b0}}, in_id} < 32'(SLOTS));
        key_r   <= KEY_BITS'(in_key);
      end
      slle_pkg::OP_KEY_PREV_CUR, slle_pkg::OP_KEY_PREV_SENT: begin
      end
      slle_pkg::OP_KEY_NEXT_SENT: begin
        at <= SENT;
      end
      slle_pkg::OP_WALK_START: begin
        nx <= next_rd;
      end
      slle_pkg::OP_WALK_STEP: begin
        at <= nx;
        nx <= next_rd;
      end
      slle_pkg::OP_AT_LATCH: begin
        at <= prev_rd;
      end
      slle_pkg::OP_NX_LATCH: begin
        nx <= next_rd;
      end
      slle_pkg::OP_HEADK_RD: begin
        head <= next_rd;
      end
      default: begin
      end
    endcase
  end

  // The walk stops at the sentinel or at the first key above the new one.
  assign dp_stat.cmd     = cmd_r;
  assign dp_stat.id_ok   = id_ok_r;
  assign dp_stat.listed  = in_list[id_k];
  assign dp_stat.key_max = (key_r == KEY_MAX);
  assign dp_stat.walk_go = (nx != SENT) && (key_rd <= key_r);

  assign res_empty     = (head == SENT);
  assign res_count     = slle_pkg::COUNT_BITS'(count);
  assign res_status    = status_r;
  assign res_head_item = res_empty ? '0 : slle_pkg::ID_BITS'(head);
  assign res_head_key  = res_empty ? '1 : slle_pkg::KEY_W'(key_rd);

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(in_list) == int'(count))
    else $error("item count differs from membership bits");

  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.op == slle_pkg::OP_HOLD) |-> ((head == SENT) == (count == '0)))
    else $error("head link disagrees with item count");
`endif

endmodule

[hw/rtl/sorted_linked_list_engine.sv]
// ----------------------------------------------------------------------------
// sorted_linked_list_engine
// Circular doubly linked list with a sentinel over a fixed store of slots,
// supporting clear, insert before cursor, sorted insert and remove.
// ----------------------------------------------------------------------------
// Usage: one request enters on the s_ stream; one response leaves on the m_
// stream for every request, in order. A request carries a command, a slot
// number and a key. The response carries the item count, a status code and
// the head slot and its key.
// Requests are handled one at a time. A sorted insert walks the list one node
// per cycle through the link and key memories, visiting at most the listed
// items plus one. A new request can be taken in the cycle after the response
// is loaded.
// The response sits in an output register; while m_tready is low the engine
// still takes the next request and works on it, holding its result until the
// register frees. Reset empties the list; the first cycle after reset
// initializes the sentinel links and no request is taken in it.
// ----------------------------------------------------------------------------
module sorted_linked_list_engine #(
  parameter int SLOTS    = 32,
  parameter int KEY_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // cmd[1:0], item_id[6:2], key[38:7], zero padding above
  input  logic [slle_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // count[5:0], status[7:6], list_empty[8], head_item[13:9], head_key[45:14]
  output logic [slle_pkg::M_TDATA_W-1:0]   m_tdata
);

  slle_pkg::dp_cmd_t                dp_cmd;
  slle_pkg::dp_stat_t               dp_stat;
  logic                             out_free, out_load;
  logic [slle_pkg::COUNT_BITS-1:0]  res_count;
  slle_pkg::stat_t                  res_status;
  logic                             res_empty;
  logic [slle_pkg::ID_BITS-1:0]     res_head_item;
  logic [slle_pkg::KEY_W-1:0]       res_head_key;

  assign out_free = !m_tvalid || m_tready;

  slle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .out_load (out_load),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat)
  );

  slle_dp #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .dp_cmd        (dp_cmd),
    .dp_stat       (dp_stat),
    .in_cmd        (s_tdata[1:0]),
    .in_id         (s_tdata[6:2]),
    .in_key        (s_tdata[38:7]),
    .res_count     (res_count),
    .res_status    (res_status),
    .res_empty     (res_empty),
    .res_head_item (res_head_item),
    .res_head_key  (res_head_key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{slle_pkg::M_PAD_W{1'b0}}, res_head_key, res_head_item, res_empty,
                  res_status, res_count};
    end
  end

`ifndef SYNTHESIS
  // Only one request is in the engine at a time.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in progress");
`endif

endmodule
